/* hdl/tlc_pkg.sv */
// Shared types and constants for the two-way traffic light controller.
package tlc_pkg;

  // Field widths
  localparam int unsigned SecW    = 7;
  localparam int unsigned LampW   = 3;
  localparam int unsigned InBytesW  = 8;
  localparam int unsigned OutBytesW = 24;

  // Reset durations, in seconds
  localparam logic [SecW-1:0] RedReset    = 7'd5;
  localparam logic [SecW-1:0] YellowReset = 7'd2;
  localparam logic [SecW-1:0] GreenReset  = 7'd3;
  localparam int unsigned     MaxDurationDefault = 99;

  typedef enum logic [1:0] {
    MODE_NORMAL     = 2'd0,
    MODE_SET_RED    = 2'd1,
    MODE_SET_YELLOW = 2'd2,
    MODE_SET_GREEN  = 2'd3
  } mode_t;

  // Phase code doubles as the lamp bit index within a direction
  typedef enum logic [1:0] {
    PH_RED    = 2'd0,
    PH_YELLOW = 2'd1,
    PH_GREEN  = 2'd2
  } phase_t;

  // Lamps after a normal-mode restart: horizontal red, vertical green
  localparam logic [2*LampW-1:0] LampRestart = 6'b100_001;

  typedef struct packed {
    logic blink_tick;
    logic second_tick;
    logic save_press;
    logic raise_press;
    logic mode_press;
  } tlc_item_t;

  typedef struct packed {
    logic [1:0]       current_mode;
    logic [SecW-1:0]  display_right;
    logic [SecW-1:0]  display_left;
    logic [LampW-1:0] lamps_vertical;
    logic [LampW-1:0] lamps_horizontal;
  } tlc_result_t;

endpackage

/* hdl/tlc_core.sv */
// Controller state and its single-pass next-state logic for one request.
module tlc_core
  import tlc_pkg::*;
#(
  parameter int unsigned MAX_DURATION = MaxDurationDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  tlc_item_t   item,
  output tlc_result_t result
);

  localparam logic [SecW:0] MaxDur = (SecW+1)'(MAX_DURATION);

  mode_t             mode, mode_next;
  logic [SecW-1:0]   edit_value, edit_value_next;
  logic [SecW-1:0]   red_seconds, red_seconds_next;
  logic [SecW-1:0]   yellow_seconds, yellow_seconds_next;
  logic [SecW-1:0]   green_seconds, green_seconds_next;
  phase_t            phase_h, phase_h_next;
  phase_t            phase_v, phase_v_next;
  logic [SecW-1:0]   count_h, count_h_next;
  logic [SecW-1:0]   count_v, count_v_next;
  logic [2*LampW-1:0] lamp_bits, lamp_bits_next;

  // Next phase in the red -> green -> yellow -> red cycle
  function automatic phase_t next_phase(input phase_t ph);
    phase_t nx;
    case (ph)
      PH_RED:    nx = PH_GREEN;
      PH_GREEN:  nx = PH_YELLOW;
      PH_YELLOW: nx = PH_RED;
      default:   nx = ph;
    endcase
    return nx;
  endfunction

  // Duration loaded when a phase begins
  function automatic logic [SecW-1:0] phase_load(input phase_t ph,
                                                 input logic [SecW-1:0] r,
                                                 input logic [SecW-1:0] y,
                                                 input logic [SecW-1:0] g);
    logic [SecW-1:0] v;
    case (ph)
      PH_RED:    v = r;
      PH_YELLOW: v = y;
      default:   v = g;
    endcase
    return v;
  endfunction

  // Next-state and result logic
  always_comb begin
    logic [LampW-1:0] lh;
    logic [LampW-1:0] lv;
    phase_t           sel;
    logic [SecW:0]    edit_inc;
    logic             ph_valid_h;
    logic             ph_valid_v;

    mode_next           = mode;
    edit_value_next     = edit_value;
    red_seconds_next    = red_seconds;
    yellow_seconds_next = yellow_seconds;
    green_seconds_next  = green_seconds;
    phase_h_next        = phase_h;
    phase_v_next        = phase_v;
    count_h_next        = count_h;
    count_v_next        = count_v;
    lamp_bits_next      = lamp_bits;
    lh                  = '0;
    lv                  = '0;
    sel                 = PH_RED;
    edit_inc            = '0;
    ph_valid_h          = 1'b0;
    ph_valid_v          = 1'b0;
    result              = '0;

    // Mode button: step through setup modes, wrap back to normal
    if (item.mode_press) begin
      if (mode == MODE_SET_GREEN) begin
        mode_next      = MODE_NORMAL;
        phase_h_next   = PH_RED;
        count_h_next   = red_seconds;
        phase_v_next   = PH_GREEN;
        count_v_next   = green_seconds;
        lamp_bits_next = LampRestart;
      end else begin
        mode_next      = mode_t'(mode + 2'd1);
        lamp_bits_next = '0;
        case (mode_next)
          MODE_SET_RED:    edit_value_next = red_seconds;
          MODE_SET_YELLOW: edit_value_next = yellow_seconds;
          default:         edit_value_next = green_seconds;
        endcase
      end
    end

    if (mode_next == MODE_NORMAL) begin
      // Countdown, saturating at zero
      if (item.second_tick) begin
        if (count_h_next != '0) count_h_next = count_h_next - 1'b1;
        if (count_v_next != '0) count_v_next = count_v_next - 1'b1;
      end
      ph_valid_h = (phase_h_next == PH_RED) || (phase_h_next == PH_YELLOW) ||
                   (phase_h_next == PH_GREEN);
      ph_valid_v = (phase_v_next == PH_RED) || (phase_v_next == PH_YELLOW) ||
                   (phase_v_next == PH_GREEN);
      lh = lamp_bits_next[LampW-1:0];
      lv = lamp_bits_next[2*LampW-1:LampW];
      // Horizontal phase change at zero
      if (count_h_next == '0 && ph_valid_h) begin
        lh[phase_h_next] = 1'b0;
        lh[next_phase(phase_h_next)] = 1'b1;
        count_h_next = phase_load(next_phase(phase_h_next), red_seconds,
                                  yellow_seconds, green_seconds);
        phase_h_next = next_phase(phase_h_next);
      end
      // Vertical phase change at zero
      if (count_v_next == '0 && ph_valid_v) begin
        lv[phase_v_next] = 1'b0;
        lv[next_phase(phase_v_next)] = 1'b1;
        count_v_next = phase_load(next_phase(phase_v_next), red_seconds,
                                  yellow_seconds, green_seconds);
        phase_v_next = next_phase(phase_v_next);
      end
      lamp_bits_next       = {lv, lh};
      result.display_left  = count_h_next;
      result.display_right = count_v_next;
    end else begin
      case (mode_next)
        MODE_SET_RED:    sel = PH_RED;
        MODE_SET_YELLOW: sel = PH_YELLOW;
        default:         sel = PH_GREEN;
      endcase
      // Blink the selected colour in both directions
      if (item.blink_tick) begin
        lamp_bits_next[sel]         = ~lamp_bits_next[sel];
        lamp_bits_next[LampW + sel] = ~lamp_bits_next[LampW + sel];
      end
      // Raise the edited duration, wrapping past the maximum to 1
      if (item.raise_press) begin
        edit_inc = {1'b0, edit_value_next} + 1'b1;
        if (edit_inc > MaxDur) edit_value_next = SecW'(1);
        else                   edit_value_next = edit_inc[SecW-1:0];
      end
      result.display_left  = edit_value_next;
      result.display_right = SecW'(mode_next);
      // Save stores the value and restarts normal mode
      if (item.save_press) begin
        case (mode_next)
          MODE_SET_RED:    red_seconds_next    = edit_value_next;
          MODE_SET_YELLOW: yellow_seconds_next = edit_value_next;
          default:         green_seconds_next  = edit_value_next;
        endcase
        mode_next      = MODE_NORMAL;
        phase_h_next   = PH_RED;
        count_h_next   = (sel == PH_RED) ? edit_value_next : red_seconds;
        phase_v_next   = PH_GREEN;
        count_v_next   = (mode_next == MODE_NORMAL && sel == PH_GREEN) ?
                         edit_value_next : green_seconds;
        lamp_bits_next = LampRestart;
        result.display_right = '0;
      end
    end

    result.lamps_horizontal = lamp_bits_next[LampW-1:0];
    result.lamps_vertical   = lamp_bits_next[2*LampW-1:LampW];
    result.current_mode     = mode_next;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_NORMAL;
      edit_value     <= '0;
      red_seconds    <= RedReset;
      yellow_seconds <= YellowReset;
      green_seconds  <= GreenReset;
      phase_h        <= PH_RED;
      phase_v        <= PH_GREEN;
      count_h        <= RedReset;
      count_v        <= GreenReset;
      lamp_bits      <= LampRestart;
    end else if (step) begin
      mode           <= mode_next;
      edit_value     <= edit_value_next;
      red_seconds    <= red_seconds_next;
      yellow_seconds <= yellow_seconds_next;
      green_seconds  <= green_seconds_next;
      phase_h        <= phase_h_next;
      phase_v        <= phase_v_next;
      count_h        <= count_h_next;
      count_v        <= count_v_next;
      lamp_bits      <= lamp_bits_next;
    end
  end

  // In normal mode each direction shows exactly its phase colour
  a_lamp_matches_phase: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_NORMAL) |->
      (lamp_bits[LampW-1:0] == (LampW'(1) << phase_h)) &&
      (lamp_bits[2*LampW-1:LampW] == (LampW'(1) << phase_v)))
    else $error("normal-mode lamps disagree with phase");

  // Stored durations stay within 1..MAX_DURATION
  a_durations_in_range: assert property (@(posedge clk) disable iff (rst)
    (red_seconds != '0) && (yellow_seconds != '0) && (green_seconds != '0) &&
    ({1'b0, red_seconds} <= MaxDur) && ({1'b0, yellow_seconds} <= MaxDur) &&
    ({1'b0, green_seconds} <= MaxDur))
    else $error("stored duration out of range");

  // A save in setup always lands in normal mode with restart lamps
  a_save_restarts: assert property (@(posedge clk) disable iff (rst)
    (step && item.save_press && (mode_next == MODE_NORMAL) &&
     (mode != MODE_NORMAL) && !item.mode_press) |=>
      (mode == MODE_NORMAL) && (lamp_bits == LampRestart))
    else $error("save did not restart normal mode");

endmodule

/* hdl/traffic_light_controller_with_setup.sv */
// Top level: request input register, controller core and result register.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+-------------------------------------
//  s_*     | in  | s_tvalid/s_tready | s_tdata[7:0]: buttons and ticks
//  m_*     | out | m_tvalid/m_tready | m_tdata[23:0]: lamps, displays, mode
//
//  One request per cycle sustained while m_tready holds high; an accepted
//  request passes the input register, then the result register, before
//  its result is valid. The single-pass next-state logic in tlc_core
//  sets the rate.
//  rst is synchronous: durations 5/2/3 s, normal mode, horizontal red,
//  vertical green, both stages empty.
//  A stalled result holds; input is still taken while the input stage is empty
//  or can drain into the result register in the same cycle.
module traffic_light_controller_with_setup
  import tlc_pkg::*;
#(
  parameter int unsigned MAX_DURATION = MaxDurationDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [0] mode_press, [1] raise_press, [2] save_press, [3] second_tick,
  // [4] blink_tick, [7:5] zero
  input  logic [InBytesW-1:0]  s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [2:0] lamps_horizontal, [5:3] lamps_vertical, [12:6] display_left,
  // [19:13] display_right, [21:20] current_mode, [23:22] zero
  output logic [OutBytesW-1:0] m_tdata
);

  logic        in_valid;
  tlc_item_t   in_item;
  logic        step;
  tlc_result_t result;

  // Input stage drains when the result register is free or being taken
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= s_tdata[4:0];
    end
  end

  tlc_core #(
    .MAX_DURATION(MAX_DURATION)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .item  (in_item),
    .result(result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {2'b00, result};
    end
  end

endmodule
